FILE: sv/tcsu_pkg.sv
// ----------------------------------------------------------------------------
// tcsu_pkg: shared types and constants of the text console scrollback unit
// Geometry of the scrollback store, command codes, item and result
// structures, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcsu_pkg;

   // geometry
   localparam int COLUMNS     = 80;
   localparam int VIEW_ROWS   = 25;
   localparam int STORE_ROWS  = 128;
   localparam int STORE_CELLS = COLUMNS * STORE_ROWS;
   localparam int VIEW_CELLS  = COLUMNS * VIEW_ROWS;
   localparam int VIEW_CAP    = (STORE_CELLS > VIEW_CELLS) ? STORE_CELLS - VIEW_CELLS : 0;
   localparam int VIEW_MAX    = (STORE_ROWS - 1) * COLUMNS;

   // field widths
   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int ROW_W   = 7;
   localparam int REQ_W   = 11;
   localparam int CELL_W  = 14;
   localparam int ADDR_W  = $clog2(STORE_CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int SUM_W   = CELL_W + 1;
   localparam int WORD_W  = CHAR_W + COLOR_W;

   // stream widths, packed fields padded to whole bytes
   localparam int REQ_BITS    = CMD_W + CHAR_W + COLOR_W + ROW_W + REQ_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 2 * CELL_W + CHAR_W + COLOR_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_VIEW    = 3'd4;

   // character constants
   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
   localparam logic [COLOR_W-1:0] BLANK_COLOR  = 4'h0;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAR_W-1:0]  character;
      logic [COLOR_W-1:0] color;
      logic [ROW_W-1:0]   row;
      logic [REQ_W-1:0]   cell_req;
   } item_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cursor;
      logic [CELL_W-1:0]  view_start;
      logic [CHAR_W-1:0]  cell_char;
      logic [COLOR_W-1:0] cell_color;
      logic               overflow;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic fill_step;
      logic scroll_step;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_fill;
      logic start_scroll;
      logic fill_last;
      logic scroll_more;
   } dp_status_type;

endpackage

FILE: sv/tcsu_datapath.sv
// ----------------------------------------------------------------------------
// tcsu_datapath: cursor, view and scrollback store of the console
// Holds the current transaction, the cursor and view registers, the cell
// memory and the result register; performs one step per controller command.
// ----------------------------------------------------------------------------
module tcsu_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tcsu_pkg::item_type     item,
   input  tcsu_pkg::dp_cmd_type   cmd,
   output tcsu_pkg::dp_status_type status,
   output tcsu_pkg::result_type   result
);
   import tcsu_pkg::*;

   localparam logic [CELL_W-1:0] STORE_CELLS_C = CELL_W'(STORE_CELLS);
   localparam logic [CELL_W-1:0] VIEW_CAP_C    = CELL_W'(VIEW_CAP);
   localparam logic [CELL_W-1:0] COLUMNS_C     = CELL_W'(COLUMNS);
   localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);

   // scrollback memory, character in the upper bits
   logic [WORD_W-1:0] cell_mem [STORE_CELLS];

   item_type          item_ff;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [CELL_W-1:0] view_ff, view_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              ovf_ff, ovf_in;
   logic              hit_ff, hit_in;
   logic [WORD_W-1:0] rd_data_ff;
   result_type        result_ff;

   logic              full;
   logic              is_put;
   logic              is_newline;
   logic [COL_W-1:0]  col_next;
   logic [SUM_W-1:0]  read_pos;
   logic              read_ok;
   logic              mem_we;
   logic              mem_re;
   logic [WORD_W-1:0] mem_wdata;

   // decode of the held transaction
   assign full       = cursor_ff >= STORE_CELLS_C;
   assign is_put     = item_ff.command == CMD_PUT;
   assign is_newline = item_ff.character == NEWLINE_CHAR;
   assign col_next   = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
   assign read_pos   = SUM_W'(view_ff) + SUM_W'(item_ff.cell_req);
   // cells at or past the cursor were never written and read as zero
   assign read_ok    = (SUM_W'(item_ff.cell_req) < SUM_W'(VIEW_CELLS))
                       && (read_pos < SUM_W'(cursor_ff));

   assign status.start_fill   = is_put && !full && is_newline;
   assign status.start_scroll = is_put && !full && !is_newline;
   assign status.fill_last    = col_ff == COL_LAST;
   assign status.scroll_more  = (SUM_W'(cursor_ff) >= SUM_W'(view_ff) + SUM_W'(VIEW_CELLS))
                                && (view_ff < VIEW_CAP_C);

   // next state of cursor, view and per-step flags
   always_comb begin
      cursor_in = cursor_ff;
      view_in   = view_ff;
      col_in    = col_ff;
      ovf_in    = ovf_ff;
      hit_in    = hit_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = {BLANK_CHAR, BLANK_COLOR};
      if (cmd.execute) begin
         ovf_in = is_put && full;
         hit_in = 1'b0;
         unique case (item_ff.command)
            CMD_PUT: begin
               if (!full && !is_newline) begin
                  mem_we    = 1'b1;
                  mem_wdata = {item_ff.character, item_ff.color};
                  cursor_in = cursor_ff + 1'b1;
                  col_in    = col_next;
               end
            end
            CMD_SCROLL_UP: begin
               if (view_ff >= COLUMNS_C) begin
                  view_in = view_ff - COLUMNS_C;
               end
            end
            CMD_SCROLL_DOWN: begin
               if (view_ff < VIEW_CAP_C) begin
                  view_in = view_ff + COLUMNS_C;
               end
            end
            CMD_READ: begin
               mem_re = read_ok;
               hit_in = read_ok;
            end
            CMD_SET_VIEW: begin
               if (int'(item_ff.row) < STORE_ROWS) begin
                  view_in = CELL_W'(item_ff.row) * COLUMNS_C;
               end
            end
            default: begin
            end
         endcase
      end
      // newline fill, one blank cell per cycle
      if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_wdata = {BLANK_CHAR, BLANK_COLOR};
         cursor_in = cursor_ff + 1'b1;
         col_in    = col_next;
      end
      // automatic scroll, one row per cycle
      if (cmd.scroll_step) begin
         view_in = view_ff + COLUMNS_C;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         view_ff   <= '0;
         col_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         view_ff   <= view_in;
         col_ff    <= col_in;
      end
   end

   // transaction, flags and result registers
   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      hit_ff <= hit_in;
      if (cmd.capture) begin
         item_ff <= item;
      end
      if (cmd.load_rsp) begin
         result_ff.cursor     <= cursor_ff;
         result_ff.view_start <= view_ff;
         result_ff.cell_char  <= hit_ff ? rd_data_ff[WORD_W-1:COLOR_W] : '0;
         result_ff.cell_color <= hit_ff ? rd_data_ff[COLOR_W-1:0] : '0;
         result_ff.overflow   <= ovf_ff;
      end
   end

   // cell memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[cursor_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[read_pos[ADDR_W-1:0]];
      end
   end

   assign result = result_ff;

`ifndef SYNTH
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= STORE_CELLS_C)
      else $error("cursor past end of store");

   a_view_bound: assert property (@(posedge clock) disable iff (reset)
      view_ff <= CELL_W'(VIEW_MAX))
      else $error("view past last store row");

   a_cursor_monotone: assert property (@(posedge clock) disable iff (reset)
      !reset |=> cursor_ff >= $past(cursor_ff))
      else $error("cursor moved backward");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("write attempted at full store");
`endif

endmodule

FILE: sv/tcsu_ctrl.sv
// ----------------------------------------------------------------------------
// tcsu_ctrl: sequencing controller of the console
// Accepts a transaction, runs the execute, newline fill and scroll steps,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module tcsu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  tcsu_pkg::dp_status_type status,
   output tcsu_pkg::dp_cmd_type    cmd
);
   import tcsu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_SCROLL,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;
   logic      accept;

   // handshake and step commands
   assign slot_free       = !rsp_tvalid_ff || rsp_tready;
   assign req_tready      = (state_ff == S_IDLE) || ((state_ff == S_RESP) && slot_free);
   assign accept          = req_tvalid && req_tready;
   assign cmd.capture     = accept;
   assign cmd.execute     = state_ff == S_EXEC;
   assign cmd.fill_step   = state_ff == S_FILL;
   assign cmd.scroll_step = (state_ff == S_SCROLL) && status.scroll_more;
   assign cmd.load_rsp    = (state_ff == S_RESP) && slot_free;
   assign rsp_tvalid      = rsp_tvalid_ff;

   // next state
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (status.start_fill) begin
               state_in = S_FILL;
            end else if (status.start_scroll) begin
               state_in = S_SCROLL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FILL: begin
            if (status.fill_last) state_in = S_SCROLL;
         end
         S_SCROLL: begin
            if (!status.scroll_more) state_in = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !cmd.load_rsp)
      else $error("result register overwritten while held");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted transaction not executed");

   a_fill_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && status.fill_last) |=> state_ff == S_SCROLL)
      else $error("newline fill ran past row end");
`endif

endmodule

FILE: sv/text_console_scrollback_unit.sv
// ----------------------------------------------------------------------------
// text_console_scrollback_unit: text console with a scrollback store
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  req_tdata, 40 bits
//   rsp       out         rsp_tvalid/rsp_tready  rsp_tdata, 48 bits
//
// Scroll, set view, read, unused commands and dropped puts pass through the execute
// and response states only; a put adds one scroll step per automatic scroll row, usually 0 or 1;
// a newline first writes blank cells up to the end of the row, up to 80 for a full row.
// The cursor doubles as fill mark: cells at or past it read as zero, so reset
// needs no clearing pass. The result register holds while rsp is stalled,
// and a new transaction is taken while the previous result waits.
// ----------------------------------------------------------------------------
module text_console_scrollback_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command[2:0], character[10:3], color[14:11], row[21:15], cell_req[32:22]
   input  logic [tcsu_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // cursor[13:0], view_start[27:14], cell_char[35:28], cell_color[39:36],
   // overflow[40]
   output logic [tcsu_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import tcsu_pkg::*;

   item_type      item;
   result_type    result;
   dp_cmd_type    cmd;
   dp_status_type status;

   // unpack the request fields
   assign item.command   = req_tdata[CMD_W-1:0];
   assign item.character = req_tdata[CMD_W +: CHAR_W];
   assign item.color     = req_tdata[CMD_W+CHAR_W +: COLOR_W];
   assign item.row       = req_tdata[CMD_W+CHAR_W+COLOR_W +: ROW_W];
   assign item.cell_req  = req_tdata[CMD_W+CHAR_W+COLOR_W+ROW_W +: REQ_W];

   // pack the result fields, zero padded
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}},
                       result.overflow, result.cell_color, result.cell_char,
                       result.view_start, result.cursor};

   tcsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcsu_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

endmodule
